// ----- rtl/c3zp_pkg.sv -----
// ----------------------------------------------------------------------------
// c3zp_pkg
// shared constants, register codes and types of the 3x3 zero-pad convolver
// ----------------------------------------------------------------------------
`default_nettype none

package c3zp_pkg;

    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 12;
    localparam int OUT_W      = 24;
    localparam int TAPS       = 3;
    localparam int ROW_CW     = TAPS * COEF_W;
    localparam int MAX_W      = 1024;
    localparam int LINE_AW    = $clog2(MAX_W);
    localparam int SIZE_W     = 11;
    localparam int ROW_W      = SIZE_W + 1;
    localparam int PROD_W     = PIX_W + COEF_W;
    localparam int RSUM_W     = PROD_W + 2;
    localparam int SUM_W      = PROD_W + 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;
    localparam int APB_AW     = 6;
    localparam int APB_DW     = 64;

    localparam logic [SIZE_W-1:0] WIDTH_LIMIT = SIZE_W'(MAX_W);

    typedef enum logic [2:0] {
        REG_COEF_TOP = 3'd0,
        REG_COEF_MID = 3'd1,
        REG_COEF_BOT = 3'd2,
        REG_WIDTH    = 3'd3,
        REG_HEIGHT   = 3'd4
    } t_reg_idx;

    typedef logic [TAPS-1:0][ROW_CW-1:0] t_coef_rows;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              restart;
    } t_frame_cfg;

    // one classified word: new window column plus what to do with it
    typedef struct packed {
        logic signed [PIX_W-1:0] top;
        logic signed [PIX_W-1:0] mid;
        logic signed [PIX_W-1:0] pix;
        logic                    emit;
        logic                    top_ok;
        logic                    bot_ok;
        logic                    left_ok;
        logic                    right_ok;
        logic                    last;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             empty;
    } t_fifo_stat;

endpackage

`default_nettype wire

// ----- rtl/c3zp_regs.sv -----
// ----------------------------------------------------------------------------
// c3zp_regs
// apb register bank: kernel rows and frame size, with clamped sizes out
// ----------------------------------------------------------------------------
`default_nettype none

module c3zp_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [c3zp_pkg::APB_AW-1:0]   paddr,
    input  wire logic [c3zp_pkg::APB_DW-1:0]   pwdata,
    output logic      [c3zp_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output c3zp_pkg::t_coef_rows               o_coef,
    output c3zp_pkg::t_frame_cfg               o_cfg
);

    c3zp_pkg::t_coef_rows              r_coef;
    logic [c3zp_pkg::SIZE_W-1:0]       r_width;
    logic [c3zp_pkg::SIZE_W-1:0]       r_height;
    logic                              wr_en;
    c3zp_pkg::t_reg_idx                idx;

    assign idx   = c3zp_pkg::t_reg_idx'(paddr[c3zp_pkg::APB_AW-1:3]);
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef    <= '0;
            r_width   <= c3zp_pkg::WIDTH_LIMIT;
            r_height  <= c3zp_pkg::WIDTH_LIMIT;
        end else begin
            if (wr_en) begin
                unique case (idx)
                    c3zp_pkg::REG_COEF_TOP: r_coef[0] <= pwdata[c3zp_pkg::ROW_CW-1:0];
                    c3zp_pkg::REG_COEF_MID: r_coef[1] <= pwdata[c3zp_pkg::ROW_CW-1:0];
                    c3zp_pkg::REG_COEF_BOT: r_coef[2] <= pwdata[c3zp_pkg::ROW_CW-1:0];
                    c3zp_pkg::REG_WIDTH:    r_width   <= pwdata[c3zp_pkg::SIZE_W-1:0];
                    c3zp_pkg::REG_HEIGHT:   r_height  <= pwdata[c3zp_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (idx)
            c3zp_pkg::REG_COEF_TOP: prdata = c3zp_pkg::APB_DW'(r_coef[0]);
            c3zp_pkg::REG_COEF_MID: prdata = c3zp_pkg::APB_DW'(r_coef[1]);
            c3zp_pkg::REG_COEF_BOT: prdata = c3zp_pkg::APB_DW'(r_coef[2]);
            c3zp_pkg::REG_WIDTH:    prdata = c3zp_pkg::APB_DW'(r_width);
            c3zp_pkg::REG_HEIGHT:   prdata = c3zp_pkg::APB_DW'(r_height);
            default:                prdata = '0;
        endcase
    end

    // zero acts as one, width saturates at the line memory depth
    // a size write restarts the frame at the same edge that stores the size
    always_comb begin
        o_cfg.width = r_width;
        if (r_width == '0) begin
            o_cfg.width = c3zp_pkg::SIZE_W'(1);
        end else if (r_width > c3zp_pkg::WIDTH_LIMIT) begin
            o_cfg.width = c3zp_pkg::WIDTH_LIMIT;
        end
        o_cfg.height  = (r_height == '0) ? c3zp_pkg::SIZE_W'(1) : r_height;
        o_cfg.restart = wr_en && ((idx == c3zp_pkg::REG_WIDTH)
                              || (idx == c3zp_pkg::REG_HEIGHT));
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

// ----- rtl/c3zp_fifo.sv -----
// ----------------------------------------------------------------------------
// c3zp_fifo
// short word queue between the line front end and the filter back end
// ----------------------------------------------------------------------------
`default_nettype none

module c3zp_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  c3zp_pkg::t_item        i_item,
    input  wire logic              i_pop,
    output c3zp_pkg::t_item        o_item,
    output c3zp_pkg::t_fifo_stat   o_stat
);

    c3zp_pkg::t_item                   r_mem [c3zp_pkg::FIFO_DEPTH];
    logic [c3zp_pkg::FIFO_AW-1:0]      r_wp;
    logic [c3zp_pkg::FIFO_AW-1:0]      r_rp;
    logic [c3zp_pkg::CNT_W-1:0]        r_cnt;
    logic                              do_push;
    logic                              do_pop;

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + c3zp_pkg::FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + c3zp_pkg::FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + c3zp_pkg::CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - c3zp_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = (r_cnt == c3zp_pkg::CNT_W'(c3zp_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

// ----- rtl/c3zp_front.sv -----
// ----------------------------------------------------------------------------
// c3zp_front
// takes words, tracks column and row, runs the two line stores and decides
// which result each word releases and which neighbors are padding
// ----------------------------------------------------------------------------
`default_nettype none

module c3zp_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_cmd,
    input  wire logic signed [c3zp_pkg::PIX_W-1:0]   i_pixel,
    input  c3zp_pkg::t_frame_cfg                     i_cfg,
    input  c3zp_pkg::t_fifo_stat                     i_fifo,
    output logic                                     o_push,
    output c3zp_pkg::t_item                          o_item
);

    localparam int PW = c3zp_pkg::PIX_W;
    localparam int RW = c3zp_pkg::ROW_W;

    logic [c3zp_pkg::LINE_AW-1:0]  r_col;
    logic [c3zp_pkg::LINE_AW-1:0]  n_col;
    logic [RW-1:0]                 r_row;
    logic [RW-1:0]                 n_row;

    // one word per entry: older row in the upper half, newer in the lower
    logic [2*PW-1:0]               r_line [c3zp_pkg::MAX_W];
    logic [2*PW-1:0]               r_rd;
    logic [2*PW-1:0]               r_fwd_word;
    logic                          r_fwd;
    logic [2*PW-1:0]               line_word;
    logic [2*PW-1:0]               wr_word;

    logic                          r_s1_vld;
    logic [c3zp_pkg::LINE_AW-1:0]  r_s1_addr;
    c3zp_pkg::t_item               r_s1;
    c3zp_pkg::t_item               n_s1;

    logic                          accept;
    logic [RW-1:0]                 w_ext;
    logic [RW-1:0]                 h_ext;
    logic [RW-1:0]                 col_inc;
    logic                          emit_a;
    logic                          emit_b;
    logic                          done;
    logic [c3zp_pkg::CNT_W:0]      used;

    assign w_ext   = RW'(i_cfg.width);
    assign h_ext   = RW'(i_cfg.height);
    assign col_inc = RW'(r_col) + RW'(1);

    // slots taken in the queue, counting the word still reading the line store
    assign used    = (c3zp_pkg::CNT_W+1)'(i_fifo.count) + (c3zp_pkg::CNT_W+1)'(r_s1_vld);
    assign o_ready = (used < (c3zp_pkg::CNT_W+1)'(c3zp_pkg::FIFO_DEPTH));
    assign accept  = i_valid && o_ready;

    // first column of a row releases the last pixel two rows up
    assign emit_a = (r_col == '0) && (r_row >= RW'(2));
    assign emit_b = (r_col != '0) && (r_row != '0);
    assign done   = emit_a && (r_row == h_ext + RW'(1));

    always_comb begin
        n_s1          = '0;
        n_s1.pix      = (!i_cmd && (r_row < h_ext)) ? i_pixel : '0;
        n_s1.emit     = emit_a || emit_b;
        n_s1.top_ok   = emit_a ? (r_row >= RW'(3)) : (r_row >= RW'(2));
        n_s1.bot_ok   = emit_a ? (r_row <= h_ext) : (r_row < h_ext);
        n_s1.left_ok  = emit_a ? (w_ext >= RW'(2)) : (r_col >= c3zp_pkg::LINE_AW'(2));
        n_s1.right_ok = !emit_a;
        n_s1.last     = done;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (done) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= w_ext) begin
            n_col = '0;
            n_row = r_row + RW'(1);
        end else begin
            n_col = col_inc[c3zp_pkg::LINE_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_fwd    <= accept && r_s1_vld && (r_col == r_s1_addr);
            priority if (i_cfg.restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1      <= n_s1;
            r_s1_addr <= r_col;
        end
        r_fwd_word <= wr_word;
    end

    // entries never written in this frame only reach padded window places
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line[r_col];
        end
        if (r_s1_vld) begin
            r_line[r_s1_addr] <= wr_word;
        end
    end

    // same column read while the word ahead writes it: take the write data
    assign line_word = r_fwd ? r_fwd_word : r_rd;
    assign wr_word   = {line_word[PW-1:0], r_s1.pix};

    always_comb begin
        o_item     = r_s1;
        o_item.top = line_word[2*PW-1:PW];
        o_item.mid = line_word[PW-1:0];
    end
    assign o_push = r_s1_vld;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_fifo.full)
        else $error("line front pushed into a full queue");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1.last) |-> r_s1.emit)
        else $error("frame end marked on a word that releases no result");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        RW'(r_col) < w_ext)
        else $error("column counter beyond row width");

    a_fwd_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_vld && $past(r_s1_vld))
        else $error("line store bypass without a write ahead");

endmodule

`default_nettype wire

// ----- rtl/c3zp_back.sv -----
// ----------------------------------------------------------------------------
// c3zp_back
// 3x3 window, nine products, row sums and final sum with output register
// ----------------------------------------------------------------------------
`default_nettype none

module c3zp_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  c3zp_pkg::t_item                        i_item,
    input  wire logic                              i_avail,
    output logic                                   o_pop,
    input  c3zp_pkg::t_coef_rows                   i_coef,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [c3zp_pkg::OUT_W-1:0]      o_data,
    output logic                                   o_last
);

    localparam int PW = c3zp_pkg::PIX_W;
    localparam int T  = c3zp_pkg::TAPS;

    logic signed [PW-1:0]                  r_win    [T][T];
    logic signed [PW-1:0]                  n_win    [T][T];
    logic signed [PW-1:0]                  r_p1_val [T][T];
    logic signed [c3zp_pkg::PROD_W-1:0]    r_p2_prod [T][T];
    logic signed [c3zp_pkg::RSUM_W-1:0]    r_p3_row [T];
    logic signed [c3zp_pkg::SUM_W-1:0]     total;
    logic signed [c3zp_pkg::COEF_W-1:0]    coef     [T][T];
    logic [T-1:0]                          row_ok;
    logic [T-1:0]                          col_ok;
    logic signed [PW-1:0]                  col_new  [T];

    logic r_p1_vld, r_p1_last;
    logic r_p2_vld, r_p2_last;
    logic r_p3_vld, r_p3_last;
    logic r_out_vld, r_out_last;
    logic signed [c3zp_pkg::OUT_W-1:0] r_out_data;
    logic adv;

    // whole pipe moves unless a result sits unclaimed at the output
    assign adv   = !r_out_vld || i_ready;
    assign o_pop = adv && i_avail;

    assign col_new[0] = i_item.top;
    assign col_new[1] = i_item.mid;
    assign col_new[2] = i_item.pix;
    assign row_ok = {i_item.bot_ok, 1'b1, i_item.top_ok};
    assign col_ok = {i_item.right_ok, 1'b1, i_item.left_ok};

    always_comb begin
        for (int j = 0; j < T; j++) begin
            n_win[j][0] = r_win[j][1];
            n_win[j][1] = r_win[j][2];
            n_win[j][2] = col_new[j];
        end
    end

    always_comb begin
        for (int j = 0; j < T; j++) begin
            for (int i = 0; i < T; i++) begin
                coef[j][i] = i_coef[j][c3zp_pkg::COEF_W*i +: c3zp_pkg::COEF_W];
            end
        end
    end

    assign total = c3zp_pkg::SUM_W'(r_p3_row[0]) + c3zp_pkg::SUM_W'(r_p3_row[1])
                 + c3zp_pkg::SUM_W'(r_p3_row[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_p1_vld  <= o_pop && i_item.emit;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_out_vld <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_win <= n_win;
        end
        if (adv) begin
            for (int j = 0; j < T; j++) begin
                for (int i = 0; i < T; i++) begin
                    r_p1_val[j][i] <= (row_ok[j] && col_ok[i]) ? n_win[j][i] : '0;
                    r_p2_prod[j][i] <= c3zp_pkg::PROD_W'(r_p1_val[j][i])
                                     * c3zp_pkg::PROD_W'(coef[j][i]);
                end
                r_p3_row[j] <= c3zp_pkg::RSUM_W'(r_p2_prod[j][0])
                             + c3zp_pkg::RSUM_W'(r_p2_prod[j][1])
                             + c3zp_pkg::RSUM_W'(r_p2_prod[j][2]);
            end
            r_p1_last  <= i_item.last;
            r_p2_last  <= r_p1_last;
            r_p3_last  <= r_p2_last;
            r_out_last <= r_p3_last;
            // arithmetic shift by the fraction bits, rounding toward minus infinity
            r_out_data <= total[c3zp_pkg::FRAC_W +: c3zp_pkg::OUT_W];
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/conv3x3_zero_pad_stream.sv -----
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_stream
// streaming 3x3 convolution with zero padding, q3.12 kernel, raster pixels
// ----------------------------------------------------------------------------
// throughput: one word per cycle while s_tready is high; the line store takes one
//   read and one write each cycle, and the queue absorbs output stalls until full
// path: word -> front register -> queue -> back stages p1, p2, p3, out -> m_tdata;
//   the result of pixel n is released by word n + width + 1 of the frame
// reset: synchronous, active low; size registers come up at 1024, kernel at 0
// the line store is not cleared: words of a new frame only read entries
//   that padding masks until this frame has written them
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_zero_pad_stream (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,   // [15:0] pixel
    input  wire logic [0:0]                     s_tuser,   // [0] cmd (1 = flush)
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [23:0]                         m_tdata,   // [23:0] filtered
    output logic                                m_tlast,   // frame_end
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [c3zp_pkg::APB_AW-1:0]    paddr,
    input  wire logic [c3zp_pkg::APB_DW-1:0]    pwdata,
    output logic      [c3zp_pkg::APB_DW-1:0]    prdata,
    output logic                                pready
);

    c3zp_pkg::t_coef_rows  coef;
    c3zp_pkg::t_frame_cfg  frame_cfg;
    c3zp_pkg::t_fifo_stat  fifo_stat;
    c3zp_pkg::t_item       push_item;
    c3zp_pkg::t_item       pop_item;
    logic                  push;
    logic                  pop;
    logic signed [c3zp_pkg::OUT_W-1:0] filtered;

    c3zp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (coef),
        .o_cfg   (frame_cfg)
    );

    c3zp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_cmd   (s_tuser[0]),
        .i_pixel (s_tdata[c3zp_pkg::PIX_W-1:0]),
        .i_cfg   (frame_cfg),
        .i_fifo  (fifo_stat),
        .o_push  (push),
        .o_item  (push_item)
    );

    c3zp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (fifo_stat)
    );

    c3zp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (pop_item),
        .i_avail (!fifo_stat.empty),
        .o_pop   (pop),
        .i_coef  (coef),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (filtered),
        .o_last  (m_tlast)
    );

    assign m_tdata = filtered;

endmodule

`default_nettype wire
